/* rtl/core/shn_pkg.sv */
// ----------------------------------------------------------------------------
// shn_pkg
// Types and constants shared by the spatial hash neighbor grid core.
// ----------------------------------------------------------------------------
package shn_pkg;

  localparam int unsigned ID_W   = 20;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned CELL_W = 31;
  localparam int unsigned FILL_W = 4;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  localparam logic [CELL_W-1:0] CELL_SIZE_RST = 31'd65536;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [ID_W-1:0]         entity_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] neighbor_id;
    logic            found;
    logic [1:0]      status;
    logic            last;
  } out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_MUL,
    ST_HLOAD,
    ST_HMOD,
    ST_HFIN,
    ST_FRD,
    ST_FILL,
    ST_ENT_RD,
    ST_ENT,
    ST_DONE,
    ST_RESP
  } shn_state_e;

endpackage

/* rtl/core/spatial_hash_neighbor_grid_core.sv */
// ----------------------------------------------------------------------------
// spatial_hash_neighbor_grid_core
// Hashed uniform grid: clear, insert and 27-cell neighbor query over a
// bucket fill memory and a bucket entry memory.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i  (shn_pkg::in_t)
//   out      output     out_valid_o/out_ready_i out_data_o (shn_pkg::out_t)
//   cfg      input      cfg_we_i                cfg_data_i (cell_size)
//
// Insert: a bit-serial cell divide, then a reciprocal hash reduction. Query: the
// same divide, then a hash reduction and fill read for each of the 27 cells and
// an entity read for each stored entity. Clear: one fill entry written per cycle.
// After reset a clearing pass over every fill entry runs before the first
// transaction is taken. One transaction is worked at a time; a stalled output
// holds the sequencer where it must emit, and the output register lets the
// next input in while the last result waits.
// ----------------------------------------------------------------------------
module spatial_hash_neighbor_grid_core #(
  parameter int unsigned TABLE_DEPTH     = 4096,
  parameter int unsigned BUCKET_CAPACITY = 8,
  parameter int unsigned MAX_NEIGHBORS   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  shn_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output shn_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [shn_pkg::CELL_W-1:0] cfg_data_i
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned RW     = AW + 1;
  localparam int unsigned SLOT_W = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
  localparam int unsigned EDEPTH = TABLE_DEPTH << SLOT_W;
  localparam int unsigned CW     = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [63:0] HI_MOD64 = 64'hFFFF_FFFF_0000_0000 % 64'(TABLE_DEPTH);
  localparam logic [RW-1:0] HI_MOD = HI_MOD64[RW-1:0];
  localparam logic [RW-1:0] TBL    = RW'(TABLE_DEPTH);
  localparam logic [31:0] TBL32  = 32'(TABLE_DEPTH);
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(TABLE_DEPTH);
  localparam logic [31:0] RECIP  = RECIP64[31:0];
  localparam logic [shn_pkg::FILL_W-1:0] CAP = shn_pkg::FILL_W'(BUCKET_CAPACITY);
  localparam logic [CW-1:0] MAXN = CW'(MAX_NEIGHBORS);

  shn_pkg::shn_state_e st_q, st_d;

  logic [shn_pkg::CELL_W-1:0] cell_size_q;
  logic [1:0]                 func_q, func_d;
  logic [shn_pkg::ID_W-1:0]   id_q, id_d;
  logic [31:0]                mx_q, my_q, mz_q, mx_d, my_d, mz_d;
  logic [1:0]                 ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic [31:0]                lo_q, lo_d;
  logic                       sgn_q, sgn_d;
  logic [2:0]                 mcnt_q, mcnt_d;
  logic [31:0]                qest_q, qest_d;
  logic [RW-1:0]              rem_q, rem_d;
  logic [AW-1:0]              bucket_q, bucket_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [shn_pkg::FILL_W-1:0] fill_n_q, fill_n_d;
  logic [shn_pkg::FILL_W-1:0] slot_q, slot_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic                       pend_q, pend_d;
  logic [shn_pkg::ID_W-1:0]   pend_id_q, pend_id_d;
  logic [1:0]                 resp_q, resp_d;
  logic                       out_valid_q, out_valid_d;
  shn_pkg::out_t              out_q, out_nx;
  logic                       out_ld, out_free;

  logic                       div_start;
  logic                       done_x, done_y, done_z;
  logic [31:0]                cx, cy, cz;

  logic                       fill_we, fill_re;
  logic [AW-1:0]              fill_waddr;
  logic [shn_pkg::FILL_W-1:0] fill_wdata, fill_rdata, fill_c;
  logic                       ent_we, ent_re;
  logic [AW+SLOT_W-1:0]       ent_waddr, ent_raddr;
  logic [shn_pkg::ID_W-1:0]   ent_rdata;

  logic [31:0]                hash_lo;
  logic [63:0]                prod;
  logic [31:0]                raw_r;
  logic [RW-1:0]              red_r, fin_r;
  logic                       last_cell;
  logic [shn_pkg::FILL_W-1:0] slot_nx;

  function automatic logic [31:0] spread_adj(logic [31:0] m, logic [1:0] o, logic [31:0] p);
    logic [31:0] r;
    unique case (o)
      2'd0:    r = m - p;
      2'd2:    r = m + p;
      default: r = m;
    endcase
    return r;
  endfunction

  shn_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(in_data_i.pos_x),
    .divisor_i(cell_size_q), .done_o(done_x), .quot_o(cx)
  );
  shn_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(in_data_i.pos_y),
    .divisor_i(cell_size_q), .done_o(done_y), .quot_o(cy)
  );
  shn_div u_div_z (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(in_data_i.pos_z),
    .divisor_i(cell_size_q), .done_o(done_z), .quot_o(cz)
  );

  shn_ram #(.WIDTH(shn_pkg::FILL_W), .DEPTH(TABLE_DEPTH)) u_fill_ram (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .re_i(fill_re), .raddr_i(bucket_q), .rdata_o(fill_rdata)
  );

  shn_ram #(.WIDTH(shn_pkg::ID_W), .DEPTH(EDEPTH)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(id_q),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  assign hash_lo = spread_adj(mx_q, ox_q, shn_pkg::PRIME_X)
                 ^ spread_adj(my_q, oy_q, shn_pkg::PRIME_Y)
                 ^ spread_adj(mz_q, oz_q, shn_pkg::PRIME_Z);

  // estimate the quotient by reciprocal; the remainder then needs at most
  // one subtract
  always_comb begin
    prod  = {32'd0, lo_q} * {32'd0, RECIP};
    raw_r = lo_q - 32'(qest_q * TBL32);
    red_r = (rem_q >= TBL) ? rem_q - TBL : rem_q;
    // sign-extended upper word adds a fixed residue
    fin_r = red_r + (sgn_q ? HI_MOD : '0);
    if (fin_r >= TBL) begin
      fin_r = fin_r - TBL;
    end
  end

  assign fill_c    = (fill_rdata > CAP) ? CAP : fill_rdata;
  assign last_cell = (ox_q == 2'd2) && (oy_q == 2'd2) && (oz_q == 2'd2);
  assign slot_nx   = slot_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;
  assign ent_raddr = {bucket_q, slot_q[SLOT_W-1:0]};
  assign ent_waddr = {bucket_q, fill_c[SLOT_W-1:0]};

  always_comb begin
    st_d       = st_q;
    func_d     = func_q;
    id_d       = id_q;
    mx_d       = mx_q;
    my_d       = my_q;
    mz_d       = mz_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    oz_d       = oz_q;
    lo_d       = lo_q;
    sgn_d      = sgn_q;
    mcnt_d     = mcnt_q;
    qest_d     = qest_q;
    rem_d      = rem_q;
    bucket_d   = bucket_q;
    clr_d      = clr_q;
    fill_n_d   = fill_n_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    resp_d     = resp_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    fill_we    = 1'b0;
    fill_re    = 1'b0;
    fill_waddr = bucket_q;
    fill_wdata = fill_c + 1'b1;
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    out_ld     = 1'b0;
    out_nx     = '{neighbor_id: pend_id_q, found: 1'b1, status: shn_pkg::STAT_OK,
                   last: 1'b0};

    unique case (st_q)
      shn_pkg::ST_INIT, shn_pkg::ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        fill_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          resp_d = shn_pkg::STAT_OK;
          st_d   = (st_q == shn_pkg::ST_INIT) ? shn_pkg::ST_IDLE : shn_pkg::ST_RESP;
        end
      end
      shn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d = in_data_i.func;
          id_d   = in_data_i.entity_id;
          priority case (in_data_i.func)
            shn_pkg::FUNC_CLEAR: begin
              clr_d = '0;
              st_d  = shn_pkg::ST_CLEAR;
            end
            shn_pkg::FUNC_INSERT, shn_pkg::FUNC_QUERY: begin
              div_start = 1'b1;
              st_d      = shn_pkg::ST_DIV;
            end
            default: st_d = shn_pkg::ST_IDLE; // unused selector: drop
          endcase
        end
      end
      shn_pkg::ST_DIV: begin
        if (done_x && done_y && done_z) begin
          st_d = shn_pkg::ST_MUL;
        end
      end
      shn_pkg::ST_MUL: begin
        mx_d   = 32'(cx * shn_pkg::PRIME_X);
        my_d   = 32'(cy * shn_pkg::PRIME_Y);
        mz_d   = 32'(cz * shn_pkg::PRIME_Z);
        ox_d   = (func_q == shn_pkg::FUNC_INSERT) ? 2'd1 : 2'd0;
        oy_d   = ox_d;
        oz_d   = ox_d;
        cnt_d  = '0;
        pend_d = 1'b0;
        st_d   = shn_pkg::ST_HLOAD;
      end
      shn_pkg::ST_HLOAD: begin
        lo_d   = hash_lo;
        sgn_d  = hash_lo[31];
        rem_d  = '0;
        mcnt_d = '0;
        st_d   = shn_pkg::ST_HMOD;
      end
      shn_pkg::ST_HMOD: begin
        mcnt_d = mcnt_q + 3'd1;
        if (mcnt_q == 3'd0) begin
          qest_d = prod[63:32];
        end else begin
          rem_d = raw_r[RW-1:0];
          st_d  = shn_pkg::ST_HFIN;
        end
      end
      shn_pkg::ST_HFIN: begin
        bucket_d = fin_r[AW-1:0];
        st_d     = shn_pkg::ST_FRD;
      end
      shn_pkg::ST_FRD: begin
        fill_re = 1'b1;
        st_d    = shn_pkg::ST_FILL;
      end
      shn_pkg::ST_FILL: begin
        if (func_q == shn_pkg::FUNC_INSERT) begin
          if (fill_c >= CAP) begin
            resp_d = shn_pkg::STAT_FULL;
          end else begin
            ent_we  = 1'b1;
            fill_we = 1'b1;
            resp_d  = shn_pkg::STAT_OK;
          end
          st_d = shn_pkg::ST_RESP;
        end else begin
          fill_n_d = fill_c;
          slot_d   = '0;
          if (fill_c != '0) begin
            st_d = shn_pkg::ST_ENT_RD;
          end else begin
            {ox_d, oy_d, oz_d} = {ox_q, oy_q, oz_q};
            if (oz_q != 2'd2) begin
              oz_d = oz_q + 2'd1;
            end else begin
              oz_d = '0;
              if (oy_q != 2'd2) begin
                oy_d = oy_q + 2'd1;
              end else begin
                oy_d = '0;
                ox_d = ox_q + 2'd1;
              end
            end
            st_d = last_cell ? shn_pkg::ST_DONE : shn_pkg::ST_HLOAD;
          end
        end
      end
      shn_pkg::ST_ENT_RD: begin
        ent_re = 1'b1;
        st_d   = shn_pkg::ST_ENT;
      end
      shn_pkg::ST_ENT: begin
        if (cnt_q == MAXN) begin
          // one more entity past the cap: close the run as truncated
          if (out_free) begin
            out_ld        = 1'b1;
            out_nx.status = shn_pkg::STAT_TRUNC;
            out_nx.last   = 1'b1;
            pend_d        = 1'b0;
            st_d          = shn_pkg::ST_IDLE;
          end
        end else if (!pend_q || out_free) begin
          out_ld    = pend_q;
          pend_d    = 1'b1;
          pend_id_d = ent_rdata;
          cnt_d     = cnt_q + 1'b1;
          slot_d    = slot_nx;
          if (slot_nx < fill_n_q) begin
            st_d = shn_pkg::ST_ENT_RD;
          end else begin
            if (oz_q != 2'd2) begin
              oz_d = oz_q + 2'd1;
            end else begin
              oz_d = '0;
              if (oy_q != 2'd2) begin
                oy_d = oy_q + 2'd1;
              end else begin
                oy_d = '0;
                ox_d = ox_q + 2'd1;
              end
            end
            st_d = last_cell ? shn_pkg::ST_DONE : shn_pkg::ST_HLOAD;
          end
        end
      end
      shn_pkg::ST_DONE: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_nx.last = 1'b1;
          if (!pend_q) begin
            out_nx.neighbor_id = '0;
            out_nx.found       = 1'b0;
          end
          pend_d = 1'b0;
          st_d   = shn_pkg::ST_IDLE;
        end
      end
      shn_pkg::ST_RESP: begin
        if (out_free) begin
          out_ld = 1'b1;
          out_nx = '{neighbor_id: '0, found: 1'b0, status: resp_q, last: 1'b1};
          st_d   = shn_pkg::ST_IDLE;
        end
      end
      default: st_d = shn_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = out_ld ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= shn_pkg::ST_INIT;
      cell_size_q <= shn_pkg::CELL_SIZE_RST;
      clr_q       <= '0;
      mcnt_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      mcnt_q      <= mcnt_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cell_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    mx_q      <= mx_d;
    my_q      <= my_d;
    mz_q      <= mz_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    oz_q      <= oz_d;
    lo_q      <= lo_d;
    sgn_q     <= sgn_d;
    qest_q    <= qest_d;
    rem_q     <= rem_d;
    bucket_q  <= bucket_d;
    fill_n_q  <= fill_n_d;
    slot_q    <= slot_d;
    pend_id_q <= pend_id_d;
    resp_q    <= resp_d;
    if (out_ld) begin
      out_q <= out_nx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while a result still waits");

  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == shn_pkg::STAT_TRUNC) |-> out_data_o.last)
    else $error("truncated status on a result that does not end the run");

  a_found_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> (out_data_o.status != shn_pkg::STAT_FULL))
    else $error("entity result carries bucket full status");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAXN)
    else $error("neighbor count passed the cap");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> (fill_wdata <= CAP))
    else $error("fill count written above bucket capacity");

endmodule

/* rtl/core/shn_ram.sv */
// ----------------------------------------------------------------------------
// shn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/shn_div.sv */
// ----------------------------------------------------------------------------
// shn_div
// Floor division of a signed 32-bit position by an unsigned 31-bit cell size,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module shn_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [shn_pkg::POS_W-1:0] dividend_i,
  input  logic [shn_pkg::CELL_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [31:0]                      quot_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic [31:0]                 a_q, a_d;
  logic [31:0]                 rem_q, rem_d;
  logic [shn_pkg::CELL_W-1:0]  den_q, den_d;
  logic                        neg_q, neg_d;
  logic [31:0]                 quot_q, quot_d;
  logic [31:0]                 rsh;
  logic                        ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    quot_d = quot_q;
    rsh    = {rem_q[30:0], a_q[31]};
    ge     = rsh >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[31];
      a_d    = dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
      rem_d  = '0;
      den_d  = (divisor_i == '0) ? shn_pkg::CELL_W'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rsh - {1'b0, den_q} : rsh;
      a_d   = {a_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // negative with remainder rounds down: -q - 1 is ~q
        if (!neg_q) begin
          quot_d = a_d;
        end else if (rem_d != '0) begin
          quot_d = ~a_d;
        end else begin
          quot_d = 32'(-a_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, insert and neighbor query transactions into the spatial hash
// grid core under random idling on both channels, checks each result in order
// against a directed row's expected value or a model of the bucket table.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned CAPACITY  = 8;
  localparam int unsigned MAX_HITS  = 64;
  localparam int unsigned SETTLE    = 5000;
  localparam int unsigned PHASE_N   = 86;
  localparam int unsigned ID_BITS   = shn_pkg::ID_W;
  localparam int unsigned CELL_BITS = shn_pkg::CELL_W;
  localparam logic [1:0]  FUNC_NONE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  shn_pkg::in_t         in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  shn_pkg::out_t        out_data;
  logic                 cfg_we = 1'b0;
  logic [CELL_BITS-1:0] cfg_data = '0;

  spatial_hash_neighbor_grid_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // grid model
  logic [CELL_BITS-1:0] grid_cell_size = shn_pkg::CELL_SIZE_RST;
  int unsigned          grid_fill [DEPTH];
  logic [ID_BITS-1:0]   grid_ids  [DEPTH][CAPACITY];
  shn_pkg::out_t        results_due[$];
  int unsigned          fail_count = 0;
  bit                   long_stall_req = 1'b0;
  bit                   send_burst = 1'b0;
  bit                   recv_burst = 1'b0;

  shn_pkg::in_t  dir_item[$];
  bit            dir_typed[$];
  shn_pkg::out_t dir_exp[$];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

  function automatic void queue_result(shn_pkg::out_t r);
    results_due = {results_due, r};
  endfunction

  function automatic logic [31:0] cell_of(logic signed [31:0] p);
    longint pp;
    longint d;
    longint q;
    pp = p;
    d = (grid_cell_size == 0) ? 1 : longint'(grid_cell_size);
    q = pp / d;
    if ((pp % d) != 0 && pp < 0) q = q - 1;
    return q[31:0];
  endfunction

  // low bits of the sign-extended XOR equal the low bits of the 32-bit XOR
  function automatic logic [11:0] bucket_of(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
    logic [31:0] h;
    h = (x * shn_pkg::PRIME_X) ^ (y * shn_pkg::PRIME_Y) ^ (z * shn_pkg::PRIME_Z);
    return h[11:0];
  endfunction

  function automatic shn_pkg::out_t mk_out(logic [ID_BITS-1:0] id, logic fnd,
                                           logic [1:0] st, logic lst);
    shn_pkg::out_t r;
    r.neighbor_id = id;
    r.found = fnd;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic void grid_apply(shn_pkg::in_t it, bit log_results);
    logic [31:0]   cx, cy, cz;
    logic [11:0]   b;
    bit            trunc;
    shn_pkg::out_t hits[$];
    cx = cell_of(it.pos_x);
    cy = cell_of(it.pos_y);
    cz = cell_of(it.pos_z);
    trunc = 1'b0;
    case (it.func)
      shn_pkg::FUNC_CLEAR: begin
        foreach (grid_fill[i]) grid_fill[i] = 0;
        hits = {hits, mk_out('0, 1'b0, shn_pkg::STAT_OK, 1'b1)};
      end
      shn_pkg::FUNC_INSERT: begin
        b = bucket_of(cx, cy, cz);
        if (grid_fill[b] >= CAPACITY) begin
          hits = {hits, mk_out('0, 1'b0, shn_pkg::STAT_FULL, 1'b1)};
        end else begin
          grid_ids[b][grid_fill[b]] = it.entity_id;
          grid_fill[b]++;
          hits = {hits, mk_out('0, 1'b0, shn_pkg::STAT_OK, 1'b1)};
        end
      end
      shn_pkg::FUNC_QUERY: begin
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++) begin
              b = bucket_of(cx + dx, cy + dy, cz + dz);
              for (int k = 0; k < grid_fill[b]; k++) begin
                if (hits.size() >= MAX_HITS) begin
                  trunc = 1'b1;
                  break;
                end
                hits = {hits, mk_out(grid_ids[b][k], 1'b1, shn_pkg::STAT_OK, 1'b0)};
              end
            end
        if (hits.size() == 0) hits = {hits, mk_out('0, 1'b0, shn_pkg::STAT_OK, 1'b1)};
        hits[hits.size()-1].last = 1'b1;
        if (trunc) hits[hits.size()-1].status = shn_pkg::STAT_TRUNC;
      end
      default: ;
    endcase
    if (log_results) foreach (hits[i]) queue_result(hits[i]);
  endfunction

  task automatic send(shn_pkg::in_t it, bit typed, shn_pkg::out_t want);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    grid_apply(it, !typed);
    if (typed) queue_result(want);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    // a clear or an unused selector may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cell_size(logic [CELL_BITS-1:0] v);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    grid_cell_size = v;
  endtask

  function automatic logic [31:0] near_pos(int span);
    longint csz;
    longint v;
    csz = (grid_cell_size == 0) ? 1 : longint'(grid_cell_size);
    v = longint'($urandom_range(0, 2 * span)) - span;
    v = v * csz + (longint'($urandom) % csz);
    return v[31:0];
  endfunction

  function automatic shn_pkg::in_t rand_item();
    shn_pkg::in_t it;
    int unsigned  r;
    int           span;
    r = $urandom_range(0, 99);
    if (r < 2) it.func = shn_pkg::FUNC_CLEAR;
    else if (r < 4) it.func = FUNC_NONE;
    else if (r < 52) it.func = shn_pkg::FUNC_INSERT;
    else it.func = shn_pkg::FUNC_QUERY;
    span = $urandom_range(1, 2);
    if ($urandom_range(0, 99) < 85) begin
      it.pos_x = near_pos(span);
      it.pos_y = near_pos(span);
      it.pos_z = near_pos(span);
    end else begin
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
    end
    it.entity_id = ID_BITS'($urandom);
    return it;
  endfunction

  function automatic void add_row(logic [1:0] f, logic [31:0] x, logic [31:0] y,
                                  logic [31:0] z, logic [ID_BITS-1:0] id, bit typed,
                                  shn_pkg::out_t want);
    shn_pkg::in_t it;
    it.func = f;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.entity_id = id;
    dir_item = {dir_item, it};
    dir_typed = {dir_typed, typed};
    dir_exp = {dir_exp, want};
  endfunction

  // ready side: random holds, bursts, and one long hold-off
  initial begin
    int unsigned n;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 19) == 0) recv_burst = ~recv_burst;
        n = recv_burst ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    shn_pkg::out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: id %0h found %0b status %0d last %0b",
               out_data.neighbor_id, out_data.found, out_data.status, out_data.last);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data.neighbor_id !== want.neighbor_id) begin
          $error("neighbor_id: expected %0h, got %0h", want.neighbor_id,
                 out_data.neighbor_id);
          fail_count++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    shn_pkg::out_t        done_ok;
    shn_pkg::out_t        none;
    logic [CELL_BITS-1:0] phase_size [5];
    int unsigned          sent;
    shn_pkg::in_t         it;
    done_ok = mk_out('0, 1'b0, shn_pkg::STAT_OK, 1'b1);
    none = '0;
    foreach (grid_fill[i]) grid_fill[i] = 0;

    add_row(shn_pkg::FUNC_CLEAR, '0, '0, '0, '0, 1'b1, done_ok);
    add_row(shn_pkg::FUNC_QUERY, '0, '0, '0, '0, 1'b1, done_ok);
    add_row(shn_pkg::FUNC_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'hFFFFF,
            1'b1, done_ok);
    // the most negative corner lands in bucket 0, the same as cell (0, 0, 0)
    add_row(shn_pkg::FUNC_INSERT, 32'h80000000, 32'h80000000, 32'h80000000, 20'h00000,
            1'b1, done_ok);
    add_row(FUNC_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF, 1'b0, none);
    for (int k = 0; k < CAPACITY - 1; k++)
      add_row(shn_pkg::FUNC_INSERT, 32'h8000, 32'h8000, 32'h8000, 20'h100 + 20'(k),
              1'b1, done_ok);
    add_row(shn_pkg::FUNC_INSERT, 32'h8000, 32'h8000, 32'h8000, 20'hABCDE, 1'b1,
            mk_out('0, 1'b0, shn_pkg::STAT_FULL, 1'b1));
    add_row(shn_pkg::FUNC_QUERY, '0, '0, '0, '0, 1'b0, none);
    add_row(shn_pkg::FUNC_QUERY, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, 1'b0, none);
    add_row(shn_pkg::FUNC_QUERY, 32'h80000000, 32'h80000000, 32'h80000000, '0, 1'b0, none);
    add_row(shn_pkg::FUNC_INSERT, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 20'h55555,
            1'b1, done_ok);
    add_row(shn_pkg::FUNC_QUERY, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, '0, 1'b0, none);
    add_row(shn_pkg::FUNC_CLEAR, '0, '0, '0, '0, 1'b1, done_ok);
    add_row(shn_pkg::FUNC_QUERY, 32'h8000, 32'h8000, 32'h8000, '0, 1'b1, done_ok);

    phase_size[0] = 31'd1;
    phase_size[1] = 31'h7FFFFFFF;
    phase_size[2] = 31'd0;
    phase_size[3] = CELL_BITS'($urandom_range(2, 1 << 20));
    phase_size[4] = shn_pkg::CELL_SIZE_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_item[i]) send(dir_item[i], dir_typed[i], dir_exp[i]);

    foreach (phase_size[p]) begin
      write_cell_size(phase_size[p]);
      if (p == 0) long_stall_req = 1'b1;
      sent = 0;
      while (sent < PHASE_N) begin
        it = rand_item();
        send(it, 1'b0, none);
        if (it.func != FUNC_NONE) sent++;
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* spatial_hash_neighbor_grid_core.f */
rtl/core/shn_pkg.sv
rtl/core/shn_ram.sv
rtl/core/shn_div.sv
rtl/core/spatial_hash_neighbor_grid_core.sv
test/testbench.sv
